/* rtl/q2e_pkg.sv */
// Shared widths, constants, types and helper functions for the quaternion to Euler unit.
package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;
  localparam int IN_W              = 16;
  localparam int PROD_W            = 32;
  localparam int SUM_W             = 34;
  localparam int XW                = 38;
  localparam int ZW                = 34;
  localparam int SQ_W              = 58;
  localparam int ROOT_BITS         = 29;
  localparam int MAG_W             = 28;
  localparam int OUT_W             = 16;
  localparam int PITCH_W           = 15;

  localparam logic signed [SUM_W-1:0] UNIT28      = 34'sd268435456;
  localparam logic signed [ZW-1:0]    ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [OUT_W-1:0] OUT_PI      = 16'sd25736;
  localparam logic signed [OUT_W-1:0] OUT_HALF_PI = 16'sd12868;
  localparam logic signed [ZW:0]      ROUND_HALF  = 35'sd65536;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_entry(int unsigned i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return ZW'(v);
  endfunction

  // Turn a left-half-plane vector by a quarter turn and seed the angle.
  function automatic cordic_t cordic_prep(logic signed [XW-1:0] y, logic signed [XW-1:0] x);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = ANG_HALF_PI;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -ANG_HALF_PI;
      end
    end
    return r;
  endfunction

  // Round half up to Q2.13 and saturate to +-lim.
  function automatic logic signed [OUT_W-1:0] to_q13(logic signed [ZW-1:0] z,
                                                     logic signed [OUT_W-1:0] lim);
    logic signed [ZW:0]    t;
    logic signed [ZW-17:0] r;
    logic signed [ZW-17:0] l;
    t = (ZW+1)'(z) + ROUND_HALF;
    r = t[ZW:17];
    l = (ZW-16)'(lim);
    if (r > l) begin
      return lim;
    end
    if (r < -l) begin
      return -lim;
    end
    return OUT_W'(r);
  endfunction

endpackage

/* rtl/q2e_if.sv */
// Request channels: quaternion in and Euler angles out.
interface q2e_quat_if;
  logic                                valid;
  logic                                ready;
  logic signed [q2e_pkg::IN_W-1:0]     quat_w;
  logic signed [q2e_pkg::IN_W-1:0]     quat_x;
  logic signed [q2e_pkg::IN_W-1:0]     quat_y;
  logic signed [q2e_pkg::IN_W-1:0]     quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  logic                                valid;
  logic                                ready;
  logic signed [q2e_pkg::OUT_W-1:0]    roll_angle;
  logic signed [q2e_pkg::PITCH_W-1:0]  pitch_angle;
  logic signed [q2e_pkg::OUT_W-1:0]    yaw_angle;
  logic                                pitch_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped, output ready);
endinterface

/* rtl/q2e_sqrt_cell.sv */
// One restoring square-root cell: decides one root bit per cycle while en_i is high.
module q2e_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [q2e_pkg::SQ_W-1:0]           rem_i,
  input  logic [q2e_pkg::ROOT_BITS-1:0]      root_i,
  output logic [q2e_pkg::SQ_W-1:0]           rem_o,
  output logic [q2e_pkg::ROOT_BITS-1:0]      root_o
);
  logic [q2e_pkg::SQ_W-1:0]      trial;
  logic                          take;
  logic [q2e_pkg::SQ_W-1:0]      rem_d, rem_q;
  logic [q2e_pkg::ROOT_BITS-1:0] root_d, root_q;

  assign trial = (q2e_pkg::SQ_W'(root_i) << (K + 1)) + (q2e_pkg::SQ_W'(1) << (2 * K));
  assign take  = rem_i >= trial;

  always_comb begin
    rem_d  = take ? rem_i - trial : rem_i;
    root_d = take ? (root_i | (q2e_pkg::ROOT_BITS'(1) << K)) : root_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

/* rtl/q2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation cell.
module q2e_cordic_cell #(
  parameter int I = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  q2e_pkg::cordic_t c_i,
  output q2e_pkg::cordic_t c_o
);
  logic signed [q2e_pkg::XW-1:0] xsh, ysh;
  logic signed [q2e_pkg::ZW-1:0] ang;
  q2e_pkg::cordic_t              c_d, c_q;

  assign xsh = c_i.x >>> I;
  assign ysh = c_i.y >>> I;
  assign ang = q2e_pkg::atan_entry(I);

  always_comb begin
    c_d.zero = c_i.zero;
    if (c_i.y > 0) begin
      c_d.x = c_i.x + ysh;
      c_d.y = c_i.y - xsh;
      c_d.z = c_i.z + ang;
    end else begin
      c_d.x = c_i.x - ysh;
      c_d.y = c_i.y + xsh;
      c_d.z = c_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;
endmodule

/* rtl/quaternion_to_euler_zyx_unit.sv */
// Top level: quaternion to ZYX Euler angles through sqrt and CORDIC cell rows.
//
//  channel   dir  payload                                              
//  quat_i    in   quat_w, quat_x, quat_y, quat_z (Q1.14)               
//  euler_o   out  roll_angle, yaw_angle (Q2.13), pitch_angle (Q1.13), pitch_clamped
//
// One request per cycle while the pipeline is not held; a request passes through the
// product, sum and square stages, the 29-cell square-root row, the CORDIC entry,
// the CORDIC row and the output register.
// The whole pipeline advances together; it holds only while a result sits at
// the output and euler_o.ready is low. Empty slots hold in place during that hold.
// Reset clears the valid bits only.
module quaternion_to_euler_zyx_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  q2e_quat_if.sink     quat_i,
  q2e_euler_if.source  euler_o
);
  localparam int NC = (CORDIC_STAGES > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int RB = q2e_pkg::ROOT_BITS;
  localparam int L  = 3 + RB + 1 + NC + 1;

  logic         en;
  logic [L-1:0] v_d, v_q;

  assign en           = !v_q[L-1] || euler_o.ready;
  assign quat_i.ready = en;
  assign v_d          = {v_q[L-2:0], quat_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  // products
  logic signed [q2e_pkg::PROD_W-1:0] wx_q, yz_q, wz_q, xy_q, xx_q, yy_q, zz_q, wy_q, zx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_i.quat_w * quat_i.quat_x;
      yz_q <= quat_i.quat_y * quat_i.quat_z;
      wz_q <= quat_i.quat_w * quat_i.quat_z;
      xy_q <= quat_i.quat_x * quat_i.quat_y;
      xx_q <= quat_i.quat_x * quat_i.quat_x;
      yy_q <= quat_i.quat_y * quat_i.quat_y;
      zz_q <= quat_i.quat_z * quat_i.quat_z;
      wy_q <= quat_i.quat_w * quat_i.quat_y;
      zx_q <= quat_i.quat_z * quat_i.quat_x;
    end
  end

  // sums
  logic signed [q2e_pkg::SUM_W-1:0] sr_q, cr_q, sy_q, cy_q, sp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= (q2e_pkg::SUM_W'(wx_q) + q2e_pkg::SUM_W'(yz_q)) <<< 1;
      cr_q <= q2e_pkg::UNIT28 - ((q2e_pkg::SUM_W'(xx_q) + q2e_pkg::SUM_W'(yy_q)) <<< 1);
      sy_q <= (q2e_pkg::SUM_W'(wz_q) + q2e_pkg::SUM_W'(xy_q)) <<< 1;
      cy_q <= q2e_pkg::UNIT28 - ((q2e_pkg::SUM_W'(yy_q) + q2e_pkg::SUM_W'(zz_q)) <<< 1);
      sp_q <= (q2e_pkg::SUM_W'(wy_q) - q2e_pkg::SUM_W'(zx_q)) <<< 1;
    end
  end

  // pitch sine squared, clamp detect, and delay lines across the sqrt row
  logic                              clamp_d;
  logic signed [q2e_pkg::SUM_W-1:0]  mag;
  logic [q2e_pkg::MAG_W-1:0]         m28;
  logic [2*q2e_pkg::MAG_W-1:0]       sq_d, sq_q;
  logic signed [q2e_pkg::SUM_W-1:0]  dsr [0:RB];
  logic signed [q2e_pkg::SUM_W-1:0]  dcr [0:RB];
  logic signed [q2e_pkg::SUM_W-1:0]  dsy [0:RB];
  logic signed [q2e_pkg::SUM_W-1:0]  dcy [0:RB];
  logic signed [q2e_pkg::SUM_W-1:0]  dsp [0:RB];
  logic                              dcl [0:RB];

  assign clamp_d = (sp_q >= q2e_pkg::UNIT28) || (sp_q <= -q2e_pkg::UNIT28);
  assign mag     = (sp_q < 0) ? -sp_q : sp_q;
  assign m28     = mag[q2e_pkg::MAG_W-1:0];
  assign sq_d    = m28 * m28;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q   <= sq_d;
      dsr[0] <= sr_q;
      dcr[0] <= cr_q;
      dsy[0] <= sy_q;
      dcy[0] <= cy_q;
      dsp[0] <= sp_q;
      dcl[0] <= clamp_d;
      for (int i = 1; i <= RB; i++) begin
        dsr[i] <= dsr[i-1];
        dcr[i] <= dcr[i-1];
        dsy[i] <= dsy[i-1];
        dcy[i] <= dcy[i-1];
        dsp[i] <= dsp[i-1];
        dcl[i] <= dcl[i-1];
      end
    end
  end

  // square-root row
  logic [q2e_pkg::SQ_W-1:0] rem  [0:RB];
  logic [RB-1:0]            root [0:RB];

  assign rem[0]  = (q2e_pkg::SQ_W'(1) << 56) - q2e_pkg::SQ_W'(sq_q);
  assign root[0] = '0;

  for (genvar g = 0; g < RB; g++) begin : g_sqrt
    q2e_sqrt_cell #(.K(RB - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem[g]),
      .root_i (root[g]),
      .rem_o  (rem[g+1]),
      .root_o (root[g+1])
    );
  end

  // CORDIC entry and rows
  q2e_pkg::cordic_t roll0_q, pitch0_q, yaw0_q;
  q2e_pkg::cordic_t c_roll  [0:NC];
  q2e_pkg::cordic_t c_pitch [0:NC];
  q2e_pkg::cordic_t c_yaw   [0:NC];
  logic [1:0]       pm [0:NC];

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll0_q  <= q2e_pkg::cordic_prep(q2e_pkg::XW'(dsr[RB]), q2e_pkg::XW'(dcr[RB]));
      yaw0_q   <= q2e_pkg::cordic_prep(q2e_pkg::XW'(dsy[RB]), q2e_pkg::XW'(dcy[RB]));
      pitch0_q <= q2e_pkg::cordic_prep(q2e_pkg::XW'(dsp[RB]), q2e_pkg::XW'(root[RB]));
      pm[0]    <= {dcl[RB], dsp[RB][q2e_pkg::SUM_W-1]};
      for (int i = 1; i <= NC; i++) begin
        pm[i] <= pm[i-1];
      end
    end
  end

  assign c_roll[0]  = roll0_q;
  assign c_pitch[0] = pitch0_q;
  assign c_yaw[0]   = yaw0_q;

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    q2e_cordic_cell #(.I(g)) u_roll (
      .clk_i (clk_i), .en_i (en), .c_i (c_roll[g]),  .c_o (c_roll[g+1])
    );
    q2e_cordic_cell #(.I(g)) u_pitch (
      .clk_i (clk_i), .en_i (en), .c_i (c_pitch[g]), .c_o (c_pitch[g+1])
    );
    q2e_cordic_cell #(.I(g)) u_yaw (
      .clk_i (clk_i), .en_i (en), .c_i (c_yaw[g]),   .c_o (c_yaw[g+1])
    );
  end

  // round, saturate, clamp
  logic signed [q2e_pkg::ZW-1:0]      zr, zp, zy;
  logic signed [q2e_pkg::OUT_W-1:0]   pq;
  logic signed [q2e_pkg::OUT_W-1:0]   roll_d, roll_q, yaw_d, yaw_q;
  logic signed [q2e_pkg::PITCH_W-1:0] pitch_d, pitch_q;
  logic                               flag_q;

  assign zr = c_roll[NC].zero  ? '0 : c_roll[NC].z;
  assign zp = c_pitch[NC].zero ? '0 : c_pitch[NC].z;
  assign zy = c_yaw[NC].zero   ? '0 : c_yaw[NC].z;

  always_comb begin
    roll_d = q2e_pkg::to_q13(zr, q2e_pkg::OUT_PI);
    yaw_d  = q2e_pkg::to_q13(zy, q2e_pkg::OUT_PI);
    if (pm[NC][1]) begin
      pq = pm[NC][0] ? -q2e_pkg::OUT_HALF_PI : q2e_pkg::OUT_HALF_PI;
    end else begin
      pq = q2e_pkg::to_q13(zp, q2e_pkg::OUT_HALF_PI);
    end
    pitch_d = pq[q2e_pkg::PITCH_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      flag_q  <= pm[NC][1];
    end
  end

  assign euler_o.valid         = v_q[L-1];
  assign euler_o.roll_angle    = roll_q;
  assign euler_o.pitch_angle   = pitch_q;
  assign euler_o.yaw_angle     = yaw_q;
  assign euler_o.pitch_clamped = flag_q;
endmodule

/* rtl/q2e_checker.sv */
// Port-level checks for the quaternion to Euler unit, bound to the top level.
module q2e_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [q2e_pkg::OUT_W-1:0]   roll_i,
  input logic signed [q2e_pkg::PITCH_W-1:0] pitch_i,
  input logic signed [q2e_pkg::OUT_W-1:0]   yaw_i,
  input logic                               clamp_i
);
  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(roll_i) && $stable(pitch_i) && $stable(yaw_i))
    else $error("result changed while stalled");

  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("request refused with free output");

  a_clamp_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clamp_i |-> (pitch_i == 15'sd12868) || (pitch_i == -15'sd12868))
    else $error("clamped pitch not at quarter turn");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> roll_i <= 16'sd25736 && roll_i >= -16'sd25736
                 && yaw_i <= 16'sd25736 && yaw_i >= -16'sd25736)
    else $error("angle out of range");
endmodule

bind quaternion_to_euler_zyx_unit q2e_checker u_q2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (quat_i.ready),
  .out_valid_i (euler_o.valid),
  .out_ready_i (euler_o.ready),
  .roll_i      (euler_o.roll_angle),
  .pitch_i     (euler_o.pitch_angle),
  .yaw_i       (euler_o.yaw_angle),
  .clamp_i     (euler_o.pitch_clamped)
);
